// ===== design/lru_key_value_cache_unit_defines.svh =====
// ----------------------------------------------------------------------------
// lru key/value cache assertion macros
// shared property forms for the port checker, sampled on clock, off in reset
// ----------------------------------------------------------------------------
`ifndef LRU_KEY_VALUE_CACHE_UNIT_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_UNIT_DEFINES_SVH

// consequence must hold in the same cycle
`define LKV_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lkv port check failed");

// consequence must hold in the following cycle
`define LKV_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lkv port check failed");

`endif

// ===== design/lkv_pkg.sv =====
// ----------------------------------------------------------------------------
// lkv package
// sizes, payload types and helpers shared by the lru key/value cache
// ----------------------------------------------------------------------------
package lkv_pkg;

   localparam int ENTRIES = 16;
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int OCC_W   = $clog2(ENTRIES + 1);
   localparam int CAP_W   = 5;
   localparam int DATA_W  = 32;

   localparam logic [CAP_W-1:0]  CAP_RESET = CAP_W'(16);
   localparam logic [DATA_W-1:0] MISS_DATA = '1;

   localparam logic OP_GET = 1'b0;
   localparam logic OP_SET = 1'b1;

   typedef struct packed {
      logic                     operation;
      logic signed [DATA_W-1:0] key;
      logic signed [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic                     hit;
      logic signed [DATA_W-1:0] data;
   } rsp_type;

   // one slot of the recency-ordered row
   typedef struct packed {
      logic              valid;
      logic [DATA_W-1:0] key;
      logic [DATA_W-1:0] value;
   } entry_type;

   // row update: cells 0..bound take their left neighbor, cell 0 takes head
   typedef struct packed {
      logic             apply;
      logic [IDX_W-1:0] bound;
      entry_type        head;
   } upd_type;

   // lookup result from the row
   typedef struct packed {
      logic              hit;
      logic [IDX_W-1:0]  pos;
      logic [DATA_W-1:0] value;
   } lookup_type;

   // capacity zero acts as one, above the slot count saturates
   function automatic logic [OCC_W-1:0] eff_capacity(input logic [CAP_W-1:0] cap);
      logic [OCC_W-1:0] r;
      if (int'(cap) > ENTRIES) begin
         r = OCC_W'(ENTRIES);
      end else if (cap == '0) begin
         r = OCC_W'(1);
      end else begin
         r = OCC_W'(cap);
      end
      return r;
   endfunction

endpackage

// ===== design/lkv_cell.sv =====
// ----------------------------------------------------------------------------
// lkv cell
// one slot: holds an entry, compares its key, loads from its left neighbor
// ----------------------------------------------------------------------------
module lkv_cell
   import lkv_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              take,
   input  entry_type         left,
   input  logic [DATA_W-1:0] lookup_key,
   output entry_type         entry,
   output logic              match
);

   logic              valid_ff, valid_in;
   logic [DATA_W-1:0] key_ff, key_in;
   logic [DATA_W-1:0] value_ff, value_in;

   always_comb begin
      valid_in = take ? left.valid : valid_ff;
      key_in   = take ? left.key   : key_ff;
      value_in = take ? left.value : value_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      key_ff   <= key_in;
      value_ff <= value_in;
   end

   assign entry = '{valid: valid_ff, key: key_ff, value: value_ff};
   assign match = valid_ff && (key_ff == lookup_key);

endmodule

// ===== design/lkv_chain.sv =====
// ----------------------------------------------------------------------------
// lkv chain
// row of cells ordered by recency, cell 0 most recent
// ----------------------------------------------------------------------------
module lkv_chain
   import lkv_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic [DATA_W-1:0] lookup_key,
   input  upd_type           ctl,
   output lookup_type        look
);

   entry_type          entries [ENTRIES];
   logic [ENTRIES-1:0] match;

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      entry_type left;
      logic      take;

      if (i == 0) begin : g_head
         assign left = ctl.head;
      end else begin : g_link
         assign left = entries[i-1];
      end

      assign take = ctl.apply && (ctl.bound >= IDX_W'(i));

      lkv_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .take       (take),
         .left       (left),
         .lookup_key (lookup_key),
         .entry      (entries[i]),
         .match      (match[i])
      );
   end

   // keys are unique among valid slots, so at most one match
   always_comb begin
      look.hit   = |match;
      look.pos   = '0;
      look.value = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (match[i]) begin
            look.pos   = look.pos | IDX_W'(i);
            look.value = look.value | entries[i].value;
         end
      end
   end

endmodule

// ===== design/lru_key_value_cache_unit.sv =====
// ----------------------------------------------------------------------------
// lru key/value cache unit
// fully associative key/value store with least-recently-used replacement
// ----------------------------------------------------------------------------
// The cache holds up to 16 key/value pairs in a row of cells kept in recency
// order, cell 0 being the most recent. A get returns hit=1 and the stored value
// and makes the entry most recent; a miss returns hit=0 with data all ones. A set
// overwrites a present key and makes it most recent, or inserts a new pair at
// the front, first dropping the least recent entry when the occupancy has
// reached the capacity register (0 acts as 1, above 16 as 16). A set gives no
// response. A request is accepted while the cache is idle; at the accepting edge every
// cell compares its key against the request in parallel and the lookup is registered,
// and in the update state the row shifts one place toward the tail up to the hit or
// fill point while the front cell loads the touched or new entry. A get can stay
// in the update state while an earlier response is still stalled in the output
// register. The store is empty after reset with no clearing pass; capacity
// resets to 16 and should only be written while the cache is idle.
// ----------------------------------------------------------------------------
module lru_key_value_cache_unit
   import lkv_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   // request channel
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_payload,
   // response channel
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_payload,
   // capacity register
   input  logic             csr_write_en,
   input  logic [CAP_W-1:0] csr_write_data
);

   typedef enum logic {
      IDLE,
      UPDATE
   } state_type;

   state_type         state_ff, state_in;
   logic [CAP_W-1:0]  cap_ff, cap_in;
   logic [OCC_W-1:0]  occ_ff, occ_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_payload_ff, rsp_payload_in;

   // request and lookup held between the compare and update cycles
   logic              op_ff, op_in;
   logic [DATA_W-1:0] key_ff, key_in;
   logic [DATA_W-1:0] value_ff, value_in;
   lookup_type        look_ff, look_in;

   lookup_type        look;
   upd_type           ctl;
   logic              accept;
   logic              blocked;
   logic              evict;

   // compare runs against the live request key while idle
   lkv_chain u_chain (
      .clock      (clock),
      .reset      (reset),
      .lookup_key (req_payload.key),
      .ctl        (ctl),
      .look       (look)
   );

   assign req_stall = (state_ff != IDLE);
   assign accept    = req_valid && !req_stall;

   // a get cannot finish while the previous response is still held
   assign blocked = (op_ff == OP_GET) && rsp_valid_ff && rsp_stall;

   // insert at full capacity drops the tail entry (position occ-1)
   assign evict = (occ_ff >= eff_capacity(cap_ff));

   always_comb begin
      ctl.apply = 1'b0;
      ctl.bound = look_ff.pos;
      ctl.head  = '{valid: 1'b1, key: key_ff, value: value_ff};
      occ_in    = occ_ff;

      if (state_ff == UPDATE && !blocked) begin
         if (look_ff.hit) begin
            // touch: move the hit entry to the front
            ctl.apply = 1'b1;
            if (op_ff == OP_GET) begin
               ctl.head.value = look_ff.value;
            end
         end else if (op_ff == OP_SET) begin
            // insert: shift the occupied part, keep occupancy on eviction
            ctl.apply = 1'b1;
            ctl.bound = IDX_W'(occ_ff - OCC_W'(evict));
            if (!evict) begin
               occ_in = occ_ff + OCC_W'(1);
            end
         end
      end
   end

   always_comb begin
      state_in       = state_ff;
      cap_in         = csr_write_en ? csr_write_data : cap_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_payload_in = rsp_payload_ff;
      op_in          = op_ff;
      key_in         = key_ff;
      value_in       = value_ff;
      look_in        = look_ff;

      case (state_ff)
         IDLE: begin
            if (accept) begin
               op_in    = req_payload.operation;
               key_in   = req_payload.key;
               value_in = req_payload.value;
               look_in  = look;
               state_in = UPDATE;
            end
         end
         UPDATE: begin
            if (!blocked) begin
               state_in = IDLE;
               if (op_ff == OP_GET) begin
                  rsp_valid_in        = 1'b1;
                  rsp_payload_in.hit  = look_ff.hit;
                  rsp_payload_in.data = look_ff.hit ? look_ff.value : MISS_DATA;
               end
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         cap_ff       <= CAP_RESET;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cap_ff       <= cap_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_payload_ff <= rsp_payload_in;
      op_ff          <= op_in;
      key_ff         <= key_in;
      value_ff       <= value_in;
      look_ff        <= look_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

// ===== design/lkv_checker.sv =====
// ----------------------------------------------------------------------------
// lkv checker
// port-level checks on the lru key/value cache, bound to the top level
// ----------------------------------------------------------------------------
`include "lru_key_value_cache_unit_defines.svh"

module lkv_checker
   import lkv_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input rsp_type          rsp_payload
);

   // a stalled response stays and holds its payload
   `LKV_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload))

   // a request transfer is followed by a busy cycle for the update
   `LKV_ASSERT_NEXT(a_busy_after_req, req_valid && !req_stall, req_stall)

   // a miss always carries all ones
   `LKV_ASSERT_SAME(a_miss_data, rsp_valid && !rsp_payload.hit, rsp_payload.data == MISS_DATA)

   // a new response only appears at the end of an update cycle
   `LKV_ASSERT_SAME(a_rsp_from_update, $rose(rsp_valid), $past(req_stall))

endmodule

bind lru_key_value_cache_unit lkv_checker u_lkv_checker (.*);
